// ===== hw/rtl/gla_pkg.sv =====
// Package for the G-code line assembler: event and command class codes,
// character constants, line limit and the shared state/result structs.
// No dependencies.
package gla_pkg;

  // Line limit; the count, index and length fields are 6 bits wide
  localparam int LINE_LIMIT = 64;
  localparam int COUNT_W    = 6;

  // Event codes
  localparam logic [2:0] EV_CHAR     = 3'd0;
  localparam logic [2:0] EV_LINE     = 3'd1;
  localparam logic [2:0] EV_HOLD     = 3'd2;
  localparam logic [2:0] EV_RESUME   = 3'd3;
  localparam logic [2:0] EV_RESET    = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;

  // Command classes reported at a line end
  localparam logic [3:0] CLS_GCODE   = 4'd0;
  localparam logic [3:0] CLS_STATUS  = 4'd1;
  localparam logic [3:0] CLS_INFO    = 4'd2;
  localparam logic [3:0] CLS_SETTING = 4'd3;
  localparam logic [3:0] CLS_GSTATE  = 4'd4;
  localparam logic [3:0] CLS_STARTUP = 4'd5;
  localparam logic [3:0] CLS_UNLOCK  = 4'd6;
  localparam logic [3:0] CLS_PARAMS  = 4'd7;
  localparam logic [3:0] CLS_HOME    = 4'd8;

  // Character constants
  localparam logic [7:0] CH_BANG   = 8'h21; // '!'
  localparam logic [7:0] CH_TILDE  = 8'h7E; // '~'
  localparam logic [7:0] CH_CAN    = 8'h18; // soft reset
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28; // '('
  localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
  localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
  localparam logic [7:0] CH_SLASH  = 8'h2F; // '/'
  localparam logic [7:0] CH_QUEST  = 8'h3F; // '?'
  localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
  localparam logic [7:0] CH_HASH   = 8'h23; // '#'
  localparam logic [7:0] CH_UC_I   = 8'h49;
  localparam logic [7:0] CH_UC_G   = 8'h47;
  localparam logic [7:0] CH_UC_N   = 8'h4E;
  localparam logic [7:0] CH_UC_X   = 8'h58;
  localparam logic [7:0] CH_UC_H   = 8'h48;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Line state carried from byte to byte
  typedef struct packed {
    logic [COUNT_W-1:0] kept_count;
    logic               in_paren;
    logic               in_semi;
    logic [7:0]         first_kept;
    logic [7:0]         second_kept;
  } line_state_t;

  // One result of the step logic
  typedef struct packed {
    logic               emit;
    logic [2:0]         event_kind;
    logic [7:0]         char_out;
    logic [COUNT_W-1:0] char_index;
    logic [COUNT_W-1:0] line_length;
    logic [3:0]         command_class;
  } step_result_t;

endpackage

// ===== hw/rtl/gla_if.sv =====
// Stream interfaces for the G-code line assembler: received bytes in,
// events out. Depends on gla_pkg for field widths.
interface gla_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gla_event_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  event_kind;
  logic [7:0]                  char_out;
  logic [gla_pkg::COUNT_W-1:0] char_index;
  logic [gla_pkg::COUNT_W-1:0] line_length;
  logic [3:0]                  command_class;

  modport source (output valid, output event_kind, output char_out, output char_index,
                  output line_length, output command_class, input ready);
  modport sink   (input valid, input event_kind, input char_out, input char_index,
                  input line_length, input command_class, output ready);
endinterface

// ===== hw/rtl/gla_step.sv =====
// Per-byte step logic of the G-code line assembler: classifies one byte,
// computes the next line state and the event it gives. Depends on gla_pkg.
module gla_step (
  input  logic [7:0]           rx_byte,
  input  gla_pkg::line_state_t cur,
  output gla_pkg::line_state_t nxt,
  output gla_pkg::step_result_t res
);

  logic [7:0] uc_byte;
  logic [3:0] line_class;

  // Fold lower case to upper case
  always_comb begin
    uc_byte = rx_byte;
    if (rx_byte inside {[gla_pkg::CH_LC_A:gla_pkg::CH_LC_Z]}) begin
      uc_byte = rx_byte - gla_pkg::CASE_DIFF;
    end
  end

  // Command class from the first two kept characters
  always_comb begin
    line_class = gla_pkg::CLS_GCODE;
    if (cur.kept_count == gla_pkg::COUNT_W'(1) && cur.first_kept == gla_pkg::CH_QUEST) begin
      line_class = gla_pkg::CLS_STATUS;
    end else if (cur.kept_count == gla_pkg::COUNT_W'(2) &&
                 cur.first_kept == gla_pkg::CH_DOLLAR) begin
      case (cur.second_kept)
        gla_pkg::CH_UC_I:   line_class = gla_pkg::CLS_INFO;
        gla_pkg::CH_DOLLAR: line_class = gla_pkg::CLS_SETTING;
        gla_pkg::CH_UC_G:   line_class = gla_pkg::CLS_GSTATE;
        gla_pkg::CH_UC_N:   line_class = gla_pkg::CLS_STARTUP;
        gla_pkg::CH_UC_X:   line_class = gla_pkg::CLS_UNLOCK;
        gla_pkg::CH_HASH:   line_class = gla_pkg::CLS_PARAMS;
        gla_pkg::CH_UC_H:   line_class = gla_pkg::CLS_HOME;
        default:            line_class = gla_pkg::CLS_GCODE;
      endcase
    end
  end

  // Byte decode, in priority order
  always_comb begin
    nxt = cur;
    res = '0;
    if (rx_byte == gla_pkg::CH_BANG) begin
      res.emit       = 1'b1;
      res.event_kind = gla_pkg::EV_HOLD;
    end else if (rx_byte == gla_pkg::CH_TILDE) begin
      res.emit       = 1'b1;
      res.event_kind = gla_pkg::EV_RESUME;
    end else if (rx_byte == gla_pkg::CH_CAN) begin
      nxt.kept_count = '0;
      nxt.in_paren   = 1'b0;
      nxt.in_semi    = 1'b0;
      res.emit       = 1'b1;
      res.event_kind = gla_pkg::EV_RESET;
    end else if (rx_byte == gla_pkg::CH_LF || rx_byte == gla_pkg::CH_CR) begin
      // comment flags clear at every line end; empty lines give nothing
      nxt.in_paren = 1'b0;
      nxt.in_semi  = 1'b0;
      if (cur.kept_count != '0) begin
        nxt.kept_count    = '0;
        res.emit          = 1'b1;
        res.event_kind    = gla_pkg::EV_LINE;
        res.line_length   = cur.kept_count;
        res.command_class = line_class;
      end
    end else if (cur.in_paren || cur.in_semi) begin
      // ')' ends only the paren comment
      if (rx_byte == gla_pkg::CH_RPAREN) begin
        nxt.in_paren = 1'b0;
      end
    end else if (rx_byte <= gla_pkg::CH_SPACE || rx_byte == gla_pkg::CH_SLASH) begin
      nxt = cur;
    end else if (rx_byte == gla_pkg::CH_LPAREN) begin
      nxt.in_paren = 1'b1;
    end else if (rx_byte == gla_pkg::CH_SEMI) begin
      nxt.in_semi = 1'b1;
    end else if (cur.kept_count >= gla_pkg::COUNT_W'(gla_pkg::LINE_LIMIT - 1)) begin
      // line full: drop byte and restart the line
      nxt.kept_count = '0;
      nxt.in_paren   = 1'b0;
      nxt.in_semi    = 1'b0;
      res.emit       = 1'b1;
      res.event_kind = gla_pkg::EV_OVERFLOW;
    end else begin
      if (cur.kept_count == gla_pkg::COUNT_W'(0)) begin
        nxt.first_kept = uc_byte;
      end else if (cur.kept_count == gla_pkg::COUNT_W'(1)) begin
        nxt.second_kept = uc_byte;
      end
      nxt.kept_count = cur.kept_count + gla_pkg::COUNT_W'(1);
      res.emit       = 1'b1;
      res.event_kind = gla_pkg::EV_CHAR;
      res.char_out   = uc_byte;
      res.char_index = cur.kept_count;
    end
  end

endmodule

// ===== hw/rtl/gla_top.sv =====
// G-code line assembler top level: input register, line state, result register.
// Depends on gla_pkg, gla_byte_if, gla_event_if and gla_step.
//
// Usage:
//   rx  : one received serial byte per transfer (valid/ready).
//   ev  : at most one event per byte (kept char, line end, feed hold,
//         cycle resume, soft reset, overflow). Bytes that give no event
//         (dropped, comment text, empty line ends) produce no transfer.
//   Path: a taken byte is held in the input register, then its event is
//   held in the result register, which drives it onto ev.
//   Throughput: one byte per cycle unless the receiver stalls; input register,
//   combinational step logic and result register form a two-deep pipeline.
//   Stall: while the result register is held by a stalled receiver, the
//   input register still takes one more byte; ready then drops until the
//   receiver takes the pending event.
//   Reset (rst, synchronous): pipeline empties, line count and comment
//   flags clear, the first and second kept characters read as zero.
module gcode_line_assembler (
  input logic         clk,
  input logic         rst,
  gla_byte_if.sink    rx,
  gla_event_if.source ev
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   advance;
  gla_pkg::line_state_t   state;
  gla_pkg::line_state_t   state_next;
  gla_pkg::step_result_t  step_res;
  logic                   out_valid;
  gla_pkg::step_result_t  out_res;

  // Step the input register into the result register when it has room
  assign advance  = in_valid && (!out_valid || ev.ready);
  assign rx.ready = !in_valid || advance;

  gla_step u_step (
    .rx_byte (in_byte),
    .cur     (state),
    .nxt     (state_next),
    .res     (step_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_res.emit;
    end else if (ev.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && step_res.emit) begin
      out_res <= step_res;
    end
  end

  assign ev.valid         = out_valid;
  assign ev.event_kind    = out_res.event_kind;
  assign ev.char_out      = out_res.char_out;
  assign ev.char_index    = out_res.char_index;
  assign ev.line_length   = out_res.line_length;
  assign ev.command_class = out_res.command_class;

endmodule
